// File: sv/pnfv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnfv_pkg
// Shared types, constants and coefficient tables for the pink-noise voice.
// ----------------------------------------------------------------------------
package pnfv_pkg;

	// Default widths of the sample and of the internal state words.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int STATE_BITS_DEF  = 32;

	// Coefficient format and digit-serial multiplier geometry.
	localparam int COEF_FRAC = 20;
	localparam int LP_FRAC   = 16;
	localparam int GAIN_FRAC = 14;
	localparam int DIGIT_W   = 4;
	localparam int NDIG      = 6;
	localparam int COEF_W    = DIGIT_W * NDIG;
	localparam int CNT_W     = $clog2(NDIG);
	localparam int NPOLE     = 6;
	localparam int POLE_W    = $clog2(NPOLE);

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int SMOOTH_W   = 16;
	localparam int GAIN_W     = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 1'b1;
	localparam logic [SMOOTH_W-1:0]  SMOOTH_RESET  = 16'd3795;
	localparam logic [GAIN_W-1:0]    GAIN_RESET    = 15'd2458;

	// Filter constants, signed with COEF_FRAC fraction bits; LP_ONE is one with LP_FRAC fraction bits.
	localparam logic signed [COEF_W-1:0] K_A0     = 24'sd1047381;
	localparam logic signed [COEF_W-1:0] K_C0     = 24'sd58215;
	localparam logic signed [COEF_W-1:0] K_A1     = 24'sd1041572;
	localparam logic signed [COEF_W-1:0] K_C1     = 24'sd78723;
	localparam logic signed [COEF_W-1:0] K_A2     = 24'sd1016070;
	localparam logic signed [COEF_W-1:0] K_C2     = 24'sd161326;
	localparam logic signed [COEF_W-1:0] K_A3     = 24'sd908591;
	localparam logic signed [COEF_W-1:0] K_C3     = 24'sd325568;
	localparam logic signed [COEF_W-1:0] K_A4     = 24'sd576717;
	localparam logic signed [COEF_W-1:0] K_C4     = 24'sd558841;
	localparam logic signed [COEF_W-1:0] K_A5     = -24'sd798595;
	localparam logic signed [COEF_W-1:0] K_C5     = -24'sd17719;
	localparam logic signed [COEF_W-1:0] K_DIRECT = 24'sd562246;
	localparam logic signed [COEF_W-1:0] K_DELAY  = 24'sd121557;
	localparam logic signed [COEF_W-1:0] K_SCALE  = 24'sd115343;
	localparam logic signed [COEF_W-1:0] LP_ONE   = 24'sd65536;

	// Passes through the shared multiplier, in the order they run.
	typedef enum logic [3:0] {
		OP_POLE0,
		OP_POLE1,
		OP_POLE2,
		OP_POLE3,
		OP_POLE4,
		OP_POLE5,
		OP_DIRECT,
		OP_DELAY,
		OP_SCALE,
		OP_LOWPASS,
		OP_GAIN
	} op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} fsm_t;

	// Control bundle from the sequencer to the datapath.
	typedef struct packed {
		logic ready;
		logic accept;
		logic start;
		logic wb;
		logic out_load;
		op_t  op;
		op_t  op_next;
	} ctrl_t;

	// Feedback coefficient of pole section idx.
	function automatic logic signed [COEF_W-1:0] pole_a(input logic [POLE_W-1:0] idx);
		logic signed [COEF_W-1:0] k;
		case (idx)
			3'd0:    k = K_A0;
			3'd1:    k = K_A1;
			3'd2:    k = K_A2;
			3'd3:    k = K_A3;
			3'd4:    k = K_A4;
			3'd5:    k = K_A5;
			default: k = '0;
		endcase
		return k;
	endfunction

	// Input coefficient of pole section idx.
	function automatic logic signed [COEF_W-1:0] pole_c(input logic [POLE_W-1:0] idx);
		logic signed [COEF_W-1:0] k;
		case (idx)
			3'd0:    k = K_C0;
			3'd1:    k = K_C1;
			3'd2:    k = K_C2;
			3'd3:    k = K_C3;
			3'd4:    k = K_C4;
			3'd5:    k = K_C5;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// File: sv/pink_noise_filter_voice_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pink_noise_filter_voice_core
// Turns one white-noise sample per beat into one pink, low-passed and
// gain-scaled voice sample. Six one-pole sections plus a direct and a
// one-sample-delayed white term form the pink noise, which is scaled by 0.11,
// smoothed by a one-pole low-pass whose coefficient is programmable, then
// multiplied by the programmable output gain, rounded and saturated. All
// arithmetic runs through one digit-serial multiply-accumulate unit that
// consumes coefficients four bits per cycle and runs the 11 passes one
// after another, each followed by a write-back. The result sits in an
// output register; the next item is accepted while it waits. Configuration
// (index 0 smoothing coefficient, index 1 output gain) should be written
// only while no item is in flight.
// ----------------------------------------------------------------------------
module pink_noise_filter_voice_core import pnfv_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int STATE_BITS  = STATE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]  white_sample,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	input  wire logic                           cfg_we,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_DATA_W-1:0]          cfg_data
);

	localparam int STATE_FRAC = STATE_BITS - 8;
	localparam int OPW        = STATE_BITS + 3;
	localparam int ACC_W      = OPW + 6;
	localparam int PROD_W     = ACC_W + COEF_W;
	localparam int W_SHIFT    = STATE_FRAC - (SAMPLE_BITS - 1);
	localparam int OUT_SHIFT  = GAIN_FRAC + W_SHIFT;
	localparam int WL         = (W_SHIFT > 0) ? W_SHIFT : 0;
	localparam int WR         = (W_SHIFT < 0) ? -W_SHIFT : 0;
	localparam int SW1        = SAMPLE_BITS + 1;

	localparam logic signed [ACC_W-1:0] BIAS_COEF = ACC_W'(64'd1 << (COEF_FRAC - 1));
	localparam logic signed [ACC_W-1:0] BIAS_LP   = ACC_W'(64'd1 << (LP_FRAC - 1));
	localparam logic signed [ACC_W-1:0] BIAS_OUT  = ACC_W'(64'd1 << (OUT_SHIFT - 1));

	// Saturate a full product to the state range.
	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [PROD_W-1:0] v
	);
		logic ovf;
		ovf = (v[PROD_W-1:STATE_BITS-1] != {(PROD_W-STATE_BITS+1){v[PROD_W-1]}});
		if (!ovf) begin
			return v[STATE_BITS-1:0];
		end else if (v[PROD_W-1]) begin
			return {1'b1, {(STATE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_BITS-1){1'b1}}};
		end
	endfunction

	// Saturate a full product to the sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [PROD_W-1:0] v
	);
		logic ovf;
		ovf = (v[PROD_W-1:SAMPLE_BITS-1] != {(PROD_W-SAMPLE_BITS+1){v[PROD_W-1]}});
		if (!ovf) begin
			return v[SAMPLE_BITS-1:0];
		end else if (v[PROD_W-1]) begin
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

	ctrl_t                     ctrl;
	logic                      mac_done;
	logic signed [PROD_W-1:0]  prod;
	logic                      out_free;

	logic [SMOOTH_W-1:0]       smooth_q;
	logic [GAIN_W-1:0]         gain_q;

	logic signed [STATE_BITS-1:0] p_q [NPOLE];
	logic signed [STATE_BITS-1:0] dly_q, lp_q, x_q, w_q;
	logic signed [OPW-1:0]        sum_q;
	logic signed [STATE_BITS-1:0] dly_d, lp_d, x_d, w_d;
	logic signed [OPW-1:0]        sum_d;
	logic signed [STATE_BITS-1:0] w_conv;

	logic signed [PROD_W-1:0]     res_sel;
	logic signed [STATE_BITS-1:0] res_state;
	logic [POLE_W-1:0]            wb_idx, rd_idx;

	logic signed [ACC_W-1:0]      mac_bias;
	logic signed [OPW-1:0]        mac_a, mac_b;
	logic signed [COEF_W-1:0]     mac_ca, mac_cb;

	logic                         out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	// White sample into the state format.
	if (W_SHIFT >= 0) begin : g_w_up
		assign w_conv = STATE_BITS'(white_sample) <<< WL;
	end else begin : g_w_down
		logic signed [SW1-1:0] w_rnd;
		assign w_rnd  = SW1'(white_sample) + SW1'(1 << (WR - 1));
		assign w_conv = STATE_BITS'(w_rnd >>> WR);
	end

	// Sequencer.
	pnfv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mac_done (mac_done),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// Shared digit-serial multiplier.
	pnfv_mac #(.OPW(OPW)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.start),
		.bias   (mac_bias),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.coef_a (mac_ca),
		.coef_b (mac_cb),
		.done   (mac_done),
		.prod   (prod)
	);

	assign in_ready = ctrl.ready;
	assign out_free = !out_valid_q || out_ready;
	assign wb_idx   = POLE_W'(ctrl.op);
	assign rd_idx   = POLE_W'(ctrl.op_next);

	// Round and saturate the finished pass, then work out the next state.
	always_comb begin
		res_sel   = (ctrl.op == OP_LOWPASS) ? (prod >>> LP_FRAC) : (prod >>> COEF_FRAC);
		res_state = sat_state(res_sel);
		sum_d     = sum_q;
		dly_d     = dly_q;
		lp_d      = lp_q;
		x_d       = x_q;
		w_d       = w_q;
		if (ctrl.accept) begin
			w_d   = w_conv;
			sum_d = OPW'(dly_q);
		end
		if (ctrl.wb) begin
			case (ctrl.op)
				OP_POLE0, OP_POLE1, OP_POLE2, OP_POLE3, OP_POLE4, OP_POLE5,
				OP_DIRECT:  sum_d = sum_q + OPW'(res_state);
				OP_DELAY:   dly_d = res_state;
				OP_SCALE:   x_d   = res_state;
				OP_LOWPASS: lp_d  = res_state;
				default:    ;
			endcase
		end
	end

	// Operands of the pass being launched; they see this cycle's write-back.
	always_comb begin
		mac_bias = BIAS_COEF;
		mac_a    = '0;
		mac_b    = '0;
		mac_ca   = '0;
		mac_cb   = '0;
		case (ctrl.op_next)
			OP_POLE0, OP_POLE1, OP_POLE2, OP_POLE3, OP_POLE4, OP_POLE5: begin
				mac_a  = OPW'(p_q[rd_idx]);
				mac_ca = pole_a(rd_idx);
				mac_b  = OPW'(w_d);
				mac_cb = pole_c(rd_idx);
			end
			OP_DIRECT: begin
				mac_a  = OPW'(w_d);
				mac_ca = K_DIRECT;
			end
			OP_DELAY: begin
				mac_a  = OPW'(w_d);
				mac_ca = K_DELAY;
			end
			OP_SCALE: begin
				mac_a  = sum_d;
				mac_ca = K_SCALE;
			end
			OP_LOWPASS: begin
				mac_bias = BIAS_LP;
				mac_a    = OPW'(x_d);
				mac_ca   = LP_ONE - COEF_W'(smooth_q);
				mac_b    = OPW'(lp_d);
				mac_cb   = COEF_W'(smooth_q);
			end
			OP_GAIN: begin
				mac_bias = BIAS_OUT;
				mac_a    = OPW'(lp_d);
				mac_ca   = COEF_W'(gain_q);
			end
			default: ;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= SMOOTH_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SMOOTHING: smooth_q <= cfg_data[SMOOTH_W-1:0];
				CFG_GAIN:      gain_q   <= cfg_data[GAIN_W-1:0];
				default:       ;
			endcase
		end
	end

	// Filter state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPOLE; i++) begin
				p_q[i] <= '0;
			end
			dly_q <= '0;
			lp_q  <= '0;
		end else begin
			dly_q <= dly_d;
			lp_q  <= lp_d;
			if (ctrl.wb && ctrl.op <= OP_POLE5) begin
				p_q[wb_idx] <= res_state;
			end
		end
	end

	// Working values of the current item.
	always_ff @(posedge clk) begin
		w_q   <= w_d;
		sum_q <= sum_d;
		x_q   <= x_d;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			sample_q <= sat_sample(prod >>> OUT_SHIFT);
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

endmodule
`default_nettype wire

// File: sv/pnfv_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnfv_mac
// Digit-serial multiply-accumulate: bias + a*coef_a + b*coef_b, with the
// coefficients consumed four bits per cycle, least significant digit first.
// ----------------------------------------------------------------------------
module pnfv_mac import pnfv_pkg::*; #(
	parameter int OPW = STATE_BITS_DEF + 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic signed [OPW+5:0]          bias,
	input  wire logic signed [OPW-1:0]          op_a,
	input  wire logic signed [OPW-1:0]          op_b,
	input  wire logic signed [COEF_W-1:0]       coef_a,
	input  wire logic signed [COEF_W-1:0]       coef_b,
	output logic                                done,
	output logic signed [OPW+5+COEF_W:0]        prod
);

	localparam int ACC_W = OPW + 6;
	localparam int PP_W  = OPW + DIGIT_W + 1;

	logic signed [OPW-1:0]    a_q, b_q;
	logic [COEF_W-1:0]        ca_q, cb_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [COEF_W-1:0]        low_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic                     last;
	logic signed [DIGIT_W:0]  da, db;
	logic signed [PP_W-1:0]   pa, pb;
	logic signed [ACC_W-1:0]  acc_sum;

	// One digit step; the top digit of a coefficient carries negative weight.
	always_comb begin
		last    = (cnt_q == CNT_W'(NDIG - 1));
		da      = last ? {ca_q[DIGIT_W-1], ca_q[DIGIT_W-1:0]} : {1'b0, ca_q[DIGIT_W-1:0]};
		db      = last ? {cb_q[DIGIT_W-1], cb_q[DIGIT_W-1:0]} : {1'b0, cb_q[DIGIT_W-1:0]};
		pa      = a_q * da;
		pb      = b_q * db;
		acc_sum = acc_q + ACC_W'(pa) + ACC_W'(pb);
	end

	// Sequencing flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operands, coefficient shifters and the accumulator. Finished low digits
	// shift into low_q so that the full product is kept.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			ca_q  <= coef_a;
			cb_q  <= coef_b;
			acc_q <= bias;
			low_q <= '0;
		end else if (busy_q) begin
			ca_q  <= ca_q >> DIGIT_W;
			cb_q  <= cb_q >> DIGIT_W;
			acc_q <= acc_sum >>> DIGIT_W;
			low_q <= {acc_sum[DIGIT_W-1:0], low_q[COEF_W-1:DIGIT_W]};
		end
	end

	assign done = done_q;
	assign prod = {acc_q, low_q};

	// A new pass is never launched over one that is still running.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("MAC restarted while busy");

	// The last digit step always flags completion.
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && last && !start |=> done_q) else $error("MAC completion missing");

	// Completion is only seen once the unit has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("MAC done while busy");

endmodule
`default_nettype wire

// File: sv/pnfv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnfv_ctrl
// Sequencer: takes a beat, walks the multiplier passes in order and hands
// the finished sample to the output register.
// ----------------------------------------------------------------------------
module pnfv_ctrl import pnfv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic mac_done,
	input  wire logic out_free,
	output ctrl_t     ctrl
);

	fsm_t state_q, state_d;
	op_t  op_q;
	logic last_op;

	assign last_op = (op_q == OP_GAIN);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (mac_done && last_op) begin
					state_d = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctrl          = '0;
		ctrl.op       = op_q;
		ctrl.op_next  = op_t'(op_q + 4'd1);
		case (state_q)
			ST_IDLE: begin
				ctrl.ready   = 1'b1;
				ctrl.accept  = in_valid;
				ctrl.start   = in_valid;
				ctrl.op_next = OP_POLE0;
			end
			ST_RUN: begin
				ctrl.wb       = mac_done;
				ctrl.start    = mac_done && !last_op;
				ctrl.out_load = mac_done && last_op && out_free;
			end
			ST_HOLD: begin
				ctrl.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_POLE0;
		end else begin
			state_q <= state_d;
			if (ctrl.start) begin
				op_q <= ctrl.op_next;
			end
		end
	end

	// A beat always starts at the first pole section.
	a_accept_first: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |=> state_q == ST_RUN && op_q == OP_POLE0)
		else $error("Item did not start at the first pass");

	// The multiplier only finishes while a sample is being worked on.
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_RUN) else $error("MAC done outside a run");

	// Only a finished sample waits for the output register.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD |-> op_q == OP_GAIN) else $error("Hold before last pass");

endmodule
`default_nettype wire

// File: tb/pink_noise_filter_voice_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pink_noise_filter_voice_checker
// Watches the sample channels and the register port of the pink-noise voice.
// Keeps its own copy of the pole sections, the delayed white term, the
// low-pass memory and both registers, works out the voice sample due for
// every accepted white sample, and compares each output beat with the oldest
// sample still owed.
// ----------------------------------------------------------------------------
module pink_noise_filter_voice_checker import pnfv_pkg::*; (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_ready,
	input  wire logic signed [SAMPLE_BITS_DEF-1:0] white_sample,
	input  wire logic                              out_valid,
	input  wire logic                              out_ready,
	input  wire logic signed [SAMPLE_BITS_DEF-1:0] sample_out,
	input  wire logic                              cfg_we,
	input  wire logic [CFG_IDX_W-1:0]              cfg_index,
	input  wire logic [CFG_DATA_W-1:0]             cfg_data,
	output int                                     fail_count,
	output int                                     pending
);

	localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
	localparam int STATE_W    = STATE_BITS_DEF;
	localparam int STATE_FRAC = STATE_W - 8;

	// Section coefficients widened to 64 bits.
	localparam longint SECTION_FB [NPOLE] = '{K_A0, K_A1, K_A2, K_A3, K_A4, K_A5};
	localparam longint SECTION_IN [NPOLE] = '{K_C0, K_C1, K_C2, K_C3, K_C4, K_C5};

	// Filter state and register copies.
	longint              section_acc [NPOLE];
	longint              delay_term;
	longint              lowpass_acc;
	logic [SMOOTH_W-1:0] smooth_reg;
	logic [GAIN_W-1:0]   gain_reg;

	// Voice samples still owed by the block, oldest first.
	logic signed [SAMPLE_W-1:0] owed_samples [$];
	logic signed [SAMPLE_W-1:0] oldest;

	initial fail_count = 0;
	initial pending = 0;

	// Divide by 2^n, rounding halves toward plus infinity.
	function automatic longint round_shift(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	// Clamp to a signed range of the given width.
	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Advance the filter by one white sample and return the voice sample.
	function automatic logic signed [SAMPLE_W-1:0] voice_sample_for(
		input logic signed [SAMPLE_W-1:0] white
	);
		longint w;
		longint acc;
		longint sum;
		longint x;
		longint a;
		longint y;
		w = longint'(white) <<< (STATE_FRAC - (SAMPLE_W - 1));
		for (int i = 0; i < NPOLE; i++) begin
			acc = SECTION_FB[i] * section_acc[i] + SECTION_IN[i] * w;
			section_acc[i] = clamp(round_shift(acc, COEF_FRAC), STATE_W);
		end
		sum = delay_term + round_shift(longint'(K_DIRECT) * w, COEF_FRAC);
		for (int i = 0; i < NPOLE; i++)
			sum += section_acc[i];
		delay_term = round_shift(longint'(K_DELAY) * w, COEF_FRAC);
		x = clamp(round_shift(sum * longint'(K_SCALE), COEF_FRAC), STATE_W);

		// Air-absorption low-pass.
		a = longint'(smooth_reg);
		acc = x * (longint'(LP_ONE) - a) + lowpass_acc * a;
		lowpass_acc = clamp(round_shift(acc, LP_FRAC), STATE_W);

		// Output gain, back to the sample format.
		y = round_shift(lowpass_acc * longint'(gain_reg),
			GAIN_FRAC + STATE_FRAC - (SAMPLE_W - 1));
		return SAMPLE_W'(clamp(y, SAMPLE_W));
	endfunction

	// Sample every channel at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPOLE; i++)
				section_acc[i] = 0;
			delay_term = 0;
			lowpass_acc = 0;
			smooth_reg = SMOOTH_RESET;
			gain_reg = GAIN_RESET;
			owed_samples.delete();
			pending = 0;
		end else begin
			// Output beat against the oldest owed sample.
			if (out_valid && out_ready) begin
				if (owed_samples.size() == 0) begin
					$error("sample_out beat with no sample owed, actual %0d", sample_out);
					fail_count++;
				end else begin
					oldest = owed_samples.pop_front();
					if (sample_out !== oldest) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							oldest, sample_out);
						fail_count++;
					end
				end
			end

			// Register writes.
			if (cfg_we) begin
				case (cfg_index)
					CFG_SMOOTHING: smooth_reg = cfg_data[SMOOTH_W-1:0];
					CFG_GAIN:      gain_reg = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			// Input beat: predict its voice sample.
			if (in_valid && in_ready)
				owed_samples.push_back(voice_sample_for(white_sample));

			pending = owed_samples.size();
		end
	end

endmodule

// File: tb/pink_noise_filter_voice_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pink_noise_filter_voice_core_tb
// Drives white samples into the pink-noise voice under several register
// settings, from the reset values to the extremes of smoothing and gain.
// A short directed run hits the rails and sign boundaries, then random runs
// mix uniform noise with long rail bursts that push the output into
// saturation. The sender idles in random bursts and the receiver stalls on
// its own pattern; the checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
module pink_noise_filter_voice_core_tb import pnfv_pkg::*; ();

	localparam int  SAMPLE_W    = SAMPLE_BITS_DEF;
	localparam int  PHASES      = 8;
	localparam int  PHASE_ITEMS = 110;
	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  SETTLE      = 100;

	localparam logic [SAMPLE_W-1:0] RAIL_POS = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] RAIL_NEG = 16'h8000;

	// Shapes of the random white-sample runs.
	typedef enum logic [2:0] {
		PAT_UNIFORM,
		PAT_RAIL,
		PAT_SMALL,
		PAT_ALTERNATE,
		PAT_NEAR_RAIL,
		PAT_DRAIN
	} pattern_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] white_sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = CFG_SMOOTHING;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	int fail_count;
	int pending;
	int cycles = 0;
	int burst_left = 0;
	int ready_hold = 0;
	int ready_pick;

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pink_noise_filter_voice_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.white_sample (white_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pink_noise_filter_voice_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.white_sample (white_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Run guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: long ready stretches, short stalls and the odd long stall.
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_pick = $urandom_range(0, 9);
			if (ready_pick < 5) begin
				out_ready = 1'b1;
				ready_hold = $urandom_range(1, 200);
			end else if (ready_pick < 9) begin
				out_ready = 1'b0;
				ready_hold = $urandom_range(1, 40);
			end else begin
				out_ready = 1'b0;
				ready_hold = $urandom_range(80, 200);
			end
		end else begin
			ready_hold--;
		end
	end

	// One register write; called at a falling edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Stop sending and wait until every owed sample has come out.
	task automatic drain_voice;
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Send one white sample; starts and ends at a falling edge.
	task automatic send_white(input logic [SAMPLE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		white_sample = v;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] smooth_val;
		logic [CFG_DATA_W-1:0] gain_val;
		logic [SAMPLE_W-1:0]   v;
		pattern_t              pat;
		int                    pick;
		int                    run_len;
		int                    sent;
		logic                  pol;

		// Reset, released at a falling edge.
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset settings: zero, rails, unit steps, bit patterns.
		send_white(16'h0000);
		send_white(RAIL_POS);
		send_white(RAIL_NEG);
		send_white(16'h0001);
		send_white(16'hFFFF);
		send_white(16'h5555);
		send_white(16'hAAAA);
		drain_voice();

		// Directed, no smoothing and the full gain field: rail bursts that
		// drive the output into saturation both ways.
		write_reg(CFG_SMOOTHING, 16'h0000);
		write_reg(CFG_GAIN, 16'hFFFF);
		repeat (9) send_white(RAIL_POS);
		repeat (9) send_white(RAIL_NEG);

		// Random runs, one register setting per phase.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_voice();
			case (ph)
				0: begin smooth_val = 16'hFFFF; gain_val = 16'd24576; end
				1: begin smooth_val = 16'h0000; gain_val = 16'd24576; end
				2: begin smooth_val = SMOOTH_RESET; gain_val = 16'(GAIN_RESET); end
				3: begin smooth_val = 16'h0001; gain_val = 16'h0000; end
				4: begin smooth_val = 16'h8000; gain_val = 16'hFFFF; end
				default: begin
					smooth_val = 16'($urandom_range(0, 65535));
					gain_val = 16'($urandom_range(0, 24576));
				end
			endcase
			write_reg(CFG_SMOOTHING, smooth_val);
			write_reg(CFG_GAIN, gain_val);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 19);
				if (pick < 8)
					pat = PAT_UNIFORM;
				else if (pick < 11)
					pat = PAT_RAIL;
				else if (pick < 13)
					pat = PAT_SMALL;
				else if (pick < 15)
					pat = PAT_ALTERNATE;
				else if (pick < 19)
					pat = PAT_NEAR_RAIL;
				else
					pat = PAT_DRAIN;

				if (pat == PAT_DRAIN) begin
					drain_voice();
				end else begin
					run_len = (pat == PAT_RAIL) ? $urandom_range(10, 40) : $urandom_range(1, 12);
					pol = 1'($urandom_range(0, 1));
					for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
						case (pat)
							PAT_RAIL:      v = pol ? RAIL_POS : RAIL_NEG;
							PAT_SMALL:     v = 16'($urandom_range(0, 64)) - 16'd32;
							PAT_ALTERNATE: v = (k % 2 == 0) ? RAIL_POS : RAIL_NEG;
							PAT_NEAR_RAIL: begin
								v = pol ? RAIL_POS - 16'($urandom_range(0, 255))
									: RAIL_NEG + 16'($urandom_range(0, 255));
							end
							default:       v = 16'($urandom);
						endcase
						send_white(v);
						sent++;
					end
				end
			end
		end

		// Let the last samples out, then a quiet stretch for stray beats.
		drain_voice();
		repeat (SETTLE) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
